[rtl/vrbp_pkg.sv]
`timescale 1ns / 1ps

package vrbp_pkg;

    // Block geometry
    localparam int BLOCK_BYTES = 512;
    localparam int BUF_BYTES   = 2 * BLOCK_BYTES;
    localparam int CHUNK_BYTES = 32;
    localparam int CHUNK_BITS  = CHUNK_BYTES * 8;
    localparam int ROWS        = BLOCK_BYTES / CHUNK_BYTES;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int OFS_W       = $clog2(CHUNK_BYTES);
    localparam int POS_W       = $clog2(BUF_BYTES);
    localparam int FILL_W      = POS_W + 1;

    // Request codes
    localparam logic [1:0] REQ_DATA = 2'd0;
    localparam logic [1:0] REQ_END  = 2'd1;
    localparam logic [1:0] REQ_LAST = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // One chunk handed from the sequencer to the output register
    typedef struct packed {
        logic                  load;
        logic [31:0]           block_number;
        logic [3:0]            chunk_index;
        logic [CHUNK_BITS-1:0] bytes;
        logic                  block_done;
        logic                  file_done;
        logic [15:0]           longest_record;
        logic [8:0]            first_free_byte;
        logic                  overflow_seen;
    } emit_t;

endpackage

[rtl/vrbp_ram.sv]
`timescale 1ns / 1ps

module vrbp_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single address, write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/vrbp_seq.sv]
`timescale 1ns / 1ps

module vrbp_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [7:0]                      data_byte,
    output logic [vrbp_pkg::ROW_W-1:0]      ram_addr,
    output logic                            ram_re,
    output logic                            ram_we_lo,
    output logic                            ram_we_hi,
    output logic [vrbp_pkg::CHUNK_BITS-1:0] ram_wdata,
    input  logic [vrbp_pkg::CHUNK_BITS-1:0] rdata_lo,
    input  logic [vrbp_pkg::CHUNK_BITS-1:0] rdata_hi,
    input  logic                            out_free,
    output vrbp_pkg::emit_t                 emit
);

    import vrbp_pkg::*;

    // Replace one byte of a row
    function automatic logic [CHUNK_BITS-1:0] ins_byte(
        input logic [CHUNK_BITS-1:0] row,
        input logic [OFS_W-1:0]      ofs,
        input logic [7:0]            b
    );
        logic [CHUNK_BITS-1:0] mask;
        logic [CHUNK_BITS-1:0] val;
        mask = CHUNK_BITS'(8'hFF) << {ofs, 3'b000};
        val  = CHUNK_BITS'(b) << {ofs, 3'b000};
        return (row & ~mask) | val;
    endfunction

    state_t                state_reg,  state_next;
    logic [FILL_W-1:0]     fill_reg,   fill_next;
    logic [POS_W-1:0]      prefix_reg, prefix_next;
    logic [15:0]           len_reg,    len_next;
    logic [31:0]           blk_reg,    blk_next;
    logic [15:0]           max_reg,    max_next;
    logic [31:0]           total_reg,  total_next;
    logic                  ovf_reg,    ovf_next;
    logic [CHUNK_BITS-1:0] cur_reg,    cur_next;
    logic                  last_reg,   last_next;
    logic [ROW_W-1:0]      k_reg,      k_next;
    logic                  half_reg,   half_next;
    logic                  final_reg,  final_next;
    logic [ROWS-1:0]       vld_lo_reg, vld_lo_next;
    logic [ROWS-1:0]       vld_hi_reg, vld_hi_next;

    logic                  accept;
    logic                  fill_in_buf;
    logic                  pfx_same_row;
    logic                  k_last;
    logic [FILL_W-1:0]     fill_pad;
    logic [FILL_W-1:0]     fill_sh;
    logic [CHUNK_BITS-1:0] lo_data;
    logic [CHUNK_BITS-1:0] hi_data;
    logic [CHUNK_BITS-1:0] pfx_old;
    logic [CHUNK_BITS-1:0] pfx_row;
    logic [CHUNK_BITS-1:0] cur_ins;
    logic [CHUNK_BITS-1:0] cur_tmp;

    // Shared decode
    assign accept       = in_valid && in_ready;
    assign fill_in_buf  = fill_reg < FILL_W'(BUF_BYTES);
    assign pfx_same_row = fill_reg[FILL_W-1:OFS_W] == {1'b0, prefix_reg[POS_W-1:OFS_W]};
    assign k_last       = k_reg == ROW_W'(ROWS - 1);
    assign fill_pad     = fill_reg + FILL_W'(fill_reg[0]);
    assign fill_sh      = fill_reg - FILL_W'(BLOCK_BYTES);

    // Rows never written since the last clear read as zero
    assign lo_data = vld_lo_reg[ram_addr] ? rdata_lo : '0;
    assign hi_data = vld_hi_reg[ram_addr] ? rdata_hi : '0;
    assign pfx_old = prefix_reg[POS_W-1] ? hi_data : lo_data;
    assign pfx_row = ins_byte(ins_byte(pfx_old, prefix_reg[OFS_W-1:0], len_reg[7:0]),
                              {prefix_reg[OFS_W-1:1], 1'b1}, len_reg[15:8]);
    assign cur_ins = ins_byte(cur_reg, fill_reg[OFS_W-1:0], data_byte);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_END || req_type == REQ_LAST))
                begin
                    state_next = ST_PFX_RD;
                end
            end
            ST_PFX_RD:
            begin
                state_next = ST_PFX_WR;
            end
            ST_PFX_WR:
            begin
                if (last_reg || fill_pad >= FILL_W'(BLOCK_BYTES))
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    if (!k_last || (last_reg && !half_reg && !final_reg))
                    begin
                        state_next = ST_EMIT_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port and handshake outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_we_lo = 1'b0;
        ram_we_hi = 1'b0;
        ram_wdata = cur_ins;
        ram_addr  = fill_reg[POS_W-2:OFS_W];
        emit      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && req_type == REQ_DATA && fill_in_buf)
                begin
                    ram_we_lo = !fill_reg[POS_W-1];
                    ram_we_hi = fill_reg[POS_W-1];
                end
            end
            ST_PFX_RD:
            begin
                ram_addr = prefix_reg[POS_W-2:OFS_W];
                ram_re   = 1'b1;
            end
            ST_PFX_WR:
            begin
                ram_addr  = prefix_reg[POS_W-2:OFS_W];
                ram_wdata = pfx_row;
                ram_we_lo = !prefix_reg[POS_W-1];
                ram_we_hi = prefix_reg[POS_W-1];
            end
            ST_EMIT_RD:
            begin
                ram_addr = k_reg;
                ram_re   = 1'b1;
            end
            ST_EMIT_LD:
            begin
                ram_addr  = k_reg;
                ram_wdata = hi_data;
                // Block shift: upper row moves down
                ram_we_lo = out_free && !last_reg;
                emit.load            = out_free;
                emit.block_number    = blk_reg + 32'(half_reg);
                emit.chunk_index     = 4'(k_reg);
                emit.bytes           = half_reg ? hi_data : lo_data;
                emit.block_done      = k_last;
                emit.file_done       = k_last && final_reg;
                emit.longest_record  = (k_last && final_reg) ? max_reg : 16'd0;
                emit.first_free_byte = (k_last && final_reg) ?
                                       9'(total_reg % BLOCK_BYTES) : 9'd0;
                emit.overflow_seen   = ovf_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        fill_next   = fill_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        blk_next    = blk_reg;
        max_next    = max_reg;
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        cur_next    = cur_reg;
        last_next   = last_reg;
        k_next      = k_reg;
        half_next   = half_reg;
        final_next  = final_reg;
        vld_lo_next = vld_lo_reg;
        vld_hi_next = vld_hi_reg;
        cur_tmp     = pfx_same_row ? pfx_row : cur_reg;

        if (ram_we_lo)
        begin
            vld_lo_next[ram_addr] = 1'b1;
        end
        if (ram_we_hi)
        begin
            vld_hi_next[ram_addr] = 1'b1;
        end

        // Pad byte into the next row starts an empty row
        if (fill_reg[0] && (&fill_reg[OFS_W-1:0]))
        begin
            cur_tmp = '0;
        end

        if (state_reg == ST_IDLE && accept)
        begin
            if (req_type == REQ_DATA)
            begin
                if (fill_in_buf)
                begin
                    cur_next  = (&fill_reg[OFS_W-1:0]) ? '0 : cur_ins;
                    fill_next = fill_reg + FILL_W'(1);
                    if (len_reg != 16'hFFFF)
                    begin
                        len_next = len_reg + 16'd1;
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            last_next = req_type == REQ_LAST;
        end

        // Close the record: prefix, pad, totals
        if (state_reg == ST_PFX_WR)
        begin
            if (len_reg > max_reg)
            begin
                max_next = len_reg;
            end
            total_next = total_reg + 32'(len_reg) + 32'(len_reg[0]) + 32'd2;
            len_next   = 16'd0;
            k_next     = '0;
            half_next  = 1'b0;
            if (last_reg)
            begin
                fill_next  = fill_pad;
                cur_next   = cur_tmp;
                final_next = !(fill_pad > FILL_W'(BLOCK_BYTES));
            end
            else if (fill_pad >= FILL_W'(BLOCK_BYTES))
            begin
                fill_next  = fill_pad;
                cur_next   = cur_tmp;
                final_next = 1'b0;
            end
            else
            begin
                prefix_next = fill_pad[POS_W-1:0];
                fill_next   = fill_pad + FILL_W'(2);
                cur_next    = (fill_pad[OFS_W-1:0] == OFS_W'(CHUNK_BYTES - 2)) ? '0 : cur_tmp;
            end
        end

        // Chunk handed over
        if (state_reg == ST_EMIT_LD && out_free)
        begin
            if (last_reg)
            begin
                if (half_reg)
                begin
                    vld_hi_next[k_reg] = 1'b0;
                end
                else
                begin
                    vld_lo_next[k_reg] = 1'b0;
                end
            end
            else
            begin
                vld_hi_next[k_reg] = 1'b0;
            end

            if (!k_last)
            begin
                k_next = k_reg + ROW_W'(1);
            end
            else if (last_reg && !half_reg && !final_reg)
            begin
                // Spill block follows
                k_next     = '0;
                half_next  = 1'b1;
                final_next = 1'b1;
            end
            else if (last_reg)
            begin
                fill_next   = FILL_W'(2);
                prefix_next = '0;
                len_next    = 16'd0;
                blk_next    = 32'd1;
                max_next    = 16'd0;
                total_next  = 32'd0;
                ovf_next    = 1'b0;
                cur_next    = '0;
                vld_lo_next = '0;
                vld_hi_next = '0;
            end
            else
            begin
                prefix_next = fill_sh[POS_W-1:0];
                fill_next   = fill_sh + FILL_W'(2);
                blk_next    = blk_reg + 32'd1;
                if (fill_sh[OFS_W-1:0] == OFS_W'(CHUNK_BYTES - 2))
                begin
                    cur_next = '0;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= FILL_W'(2);
            prefix_reg <= '0;
            len_reg    <= 16'd0;
            blk_reg    <= 32'd1;
            max_reg    <= 16'd0;
            total_reg  <= 32'd0;
            ovf_reg    <= 1'b0;
            cur_reg    <= '0;
            last_reg   <= 1'b0;
            k_reg      <= '0;
            half_reg   <= 1'b0;
            final_reg  <= 1'b0;
            vld_lo_reg <= '0;
            vld_hi_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            blk_reg    <= blk_next;
            max_reg    <= max_next;
            total_reg  <= total_next;
            ovf_reg    <= ovf_next;
            cur_reg    <= cur_next;
            last_reg   <= last_next;
            k_reg      <= k_next;
            half_reg   <= half_next;
            final_reg  <= final_next;
            vld_lo_reg <= vld_lo_next;
            vld_hi_reg <= vld_hi_next;
        end
    end

    // Both halves are never written in the same cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we_lo && ram_we_hi))
        else $error("both buffer halves written at once");

    // Fill point stays inside the buffer
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(BUF_BYTES))
        else $error("fill position past buffer end");

    // Open record always has its prefix slot below the fill point
    a_prefix_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> (FILL_W'(prefix_reg) + FILL_W'(2) <= fill_reg))
        else $error("prefix slot not below fill position");

    // End of file returns the packer to its starting point
    a_file_reset: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load && emit.file_done |=> (state_reg == ST_IDLE && fill_reg == FILL_W'(2)
                                         && blk_reg == 32'd1))
        else $error("state not restored after last block");

    // Stalled chunk keeps its index
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT_LD && !out_free |=> $stable(k_reg))
        else $error("chunk index moved while stalled");

endmodule

[rtl/variable_record_block_packer.sv]
`timescale 1ns / 1ps

// Record block packer. Each request carries a record byte, an end of record or
// an end of the last record; records are packed with a 16-bit little-endian
// length prefix and an even-byte pad into 512-byte blocks, which come out as
// sixteen 32-byte chunks. A data byte is written into its row as it is taken.
// An end of record is followed by a read-modify-write of its prefix row,
// and when it closes a block each chunk takes a row read, then a hand-over
// that moves the upper row down unless the record was the last; a last record
// can spill into a second block, and the output side may stall each hand-over.
// The two-block buffer sits in two single-port row memories, one per half;
// a valid bit per row makes every row read as zero after reset and after each
// file, so no clearing pass is needed. No request is taken while a record is
// being closed or a block is being sent.
module variable_record_block_packer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] block_number,
    output logic [3:0]  chunk_index,
    output logic [63:0] chunk_bytes_0_7,
    output logic [63:0] chunk_bytes_8_15,
    output logic [63:0] chunk_bytes_16_23,
    output logic [63:0] chunk_bytes_24_31,
    output logic        block_done,
    output logic        file_done,
    output logic [15:0] longest_record,
    output logic [8:0]  first_free_byte,
    output logic        overflow_seen
);

    import vrbp_pkg::*;

    logic [ROW_W-1:0]      ram_addr;
    logic                  ram_re;
    logic                  ram_we_lo;
    logic                  ram_we_hi;
    logic [CHUNK_BITS-1:0] ram_wdata;
    logic [CHUNK_BITS-1:0] rdata_lo;
    logic [CHUNK_BITS-1:0] rdata_hi;
    logic                  out_free;
    emit_t                 emit;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    emit_t                 out_reg;

    // Lower block rows
    vrbp_ram #(
        .WIDTH (CHUNK_BITS),
        .DEPTH (ROWS)
    ) u_ram_lo (
        .clk   (clk),
        .we    (ram_we_lo),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata_lo)
    );

    // Upper (spill) block rows
    vrbp_ram #(
        .WIDTH (CHUNK_BITS),
        .DEPTH (ROWS)
    ) u_ram_hi (
        .clk   (clk),
        .we    (ram_we_hi),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rdata_hi)
    );

    vrbp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .data_byte (data_byte),
        .ram_addr  (ram_addr),
        .ram_re    (ram_re),
        .ram_we_lo (ram_we_lo),
        .ram_we_hi (ram_we_hi),
        .ram_wdata (ram_wdata),
        .rdata_lo  (rdata_lo),
        .rdata_hi  (rdata_hi),
        .out_free  (out_free),
        .emit      (emit)
    );

    // Output register: free when empty or being taken
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_reg <= emit;
        end
    end

    assign out_valid         = out_valid_reg;
    assign block_number      = out_reg.block_number;
    assign chunk_index       = out_reg.chunk_index;
    assign chunk_bytes_0_7   = out_reg.bytes[63:0];
    assign chunk_bytes_8_15  = out_reg.bytes[127:64];
    assign chunk_bytes_16_23 = out_reg.bytes[191:128];
    assign chunk_bytes_24_31 = out_reg.bytes[255:192];
    assign block_done        = out_reg.block_done;
    assign file_done         = out_reg.file_done;
    assign longest_record    = out_reg.longest_record;
    assign first_free_byte   = out_reg.first_free_byte;
    assign overflow_seen     = out_reg.overflow_seen;

endmodule
